/* hdl/assert_macros.svh */
// Assertion macros shared by the address region attribute table RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ARAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks that a condition holds at every clock edge outside reset.
`define ARAT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`endif

/* hdl/arat_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the address region attribute table.
// Has no dependencies; used by arat_cell and address_region_attribute_table.
package arat_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned ATTR_W = 8;
    localparam int unsigned PAGE_BITS = 12;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    // Query that walks down the cell chain, one cell per cycle.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   end_addr;
        logic              size_ok;
        logic [ATTR_W-1:0] new_attr;
        logic              hit;
        logic [ATTR_W-1:0] hit_attr;
    } token_t;

    // One stored region, kept with its end precomputed at 33 bits.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W:0]   end_addr;
        logic [ATTR_W-1:0] attr;
    } entry_t;

endpackage

/* hdl/address_region_attribute_table.sv */
`timescale 1ns / 1ps
// Top level of the address region attribute table: input stage, cell chain, result stage.
// Depends on arat_pkg, arat_cell and assert_macros.svh.
`include "assert_macros.svh"

// Each transaction walks a chain of TABLE_DEPTH cells, one cell per clock, and every cell
// holding a stored region compares it against the query; the first hit in append order
// wins. The result passes through the input register, one register per cell, the result
// register and the output register before it appears on the m_ channel. One transaction
// is in the chain at a time: s_ready rises again once the previous result has moved into
// the output register, so a new transaction is not accepted before then. An append that
// succeeds (status OK) is stored into the cell at index region_count when it leaves the
// chain. Table contents are not cleared at reset; only the region count is.
module address_region_attribute_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_address,
    input  logic [31:0] s_region_size,
    input  logic [7:0]  s_region_attribute,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_attribute
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    arat_pkg::token_t       chain_tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0]   chain_vld;

    arat_pkg::token_t       in_tok_reg;
    arat_pkg::token_t       in_tok_next;
    logic                   in_vld_reg;
    logic                   busy_reg;
    logic                   busy_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   tail_vld_reg;
    logic                   tail_vld_next;
    logic [1:0]             tail_status_reg;
    logic [1:0]             tail_status_next;
    logic [7:0]             tail_attr_reg;
    logic [7:0]             tail_attr_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [1:0]             m_status_reg;
    logic [7:0]             m_attr_reg;

    logic                   s_accept;
    logic                   tail_load;
    logic                   out_load;
    logic                   append_ok;
    arat_pkg::token_t       last_tok;
    arat_pkg::entry_t       wr_data;

    assign s_ready   = !busy_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_load  = tail_vld_reg && (!m_valid_reg || m_ready);
    assign tail_load = chain_vld[TABLE_DEPTH];
    assign last_tok  = chain_tok[TABLE_DEPTH];

    // A lookup becomes the one-byte range [address, address + 1), so the cells
    // use the same interval test for both commands.
    always_comb begin
        in_tok_next          = '0;
        in_tok_next.cmd      = s_command;
        in_tok_next.addr     = s_address;
        in_tok_next.new_attr = s_region_attribute;
        in_tok_next.size_ok  = (s_region_size[arat_pkg::PAGE_BITS-1:0] == '0)
                            && (s_region_size[31:arat_pkg::PAGE_BITS] != '0);
        if (s_command == arat_pkg::CMD_LOOKUP) begin
            in_tok_next.end_addr = {1'b0, s_address} + 33'd1;
        end else begin
            in_tok_next.end_addr = {1'b0, s_address} + {1'b0, s_region_size};
        end
    end

    assign chain_tok[0] = in_tok_reg;
    assign chain_vld[0] = in_vld_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        arat_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .entry_used    (count_reg > CNT_W'(i)),
            .wr_en         (tail_load && append_ok && (count_reg == CNT_W'(i))),
            .wr_data       (wr_data),
            .tok_in_valid  (chain_vld[i]),
            .tok_in        (chain_tok[i]),
            .tok_out_valid (chain_vld[i+1]),
            .tok_out       (chain_tok[i+1])
        );
    end

    assign wr_data.start    = last_tok.addr;
    assign wr_data.end_addr = last_tok.end_addr;
    assign wr_data.attr     = last_tok.new_attr;

    assign append_ok = (last_tok.cmd == arat_pkg::CMD_APPEND)
                    && (count_reg != CNT_W'(TABLE_DEPTH))
                    && !last_tok.hit && last_tok.size_ok;

    always_comb begin
        count_next       = count_reg;
        tail_status_next = tail_status_reg;
        tail_attr_next   = tail_attr_reg;
        tail_vld_next    = tail_vld_reg;
        busy_next        = busy_reg;
        m_valid_next     = m_valid_reg;

        if (out_load) begin
            tail_vld_next = 1'b0;
            busy_next     = 1'b0;
            m_valid_next  = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_accept) begin
            busy_next = 1'b1;
        end

        if (tail_load) begin
            tail_vld_next    = 1'b1;
            tail_status_next = arat_pkg::ST_OK;
            tail_attr_next   = '0;
            case (last_tok.cmd)
                arat_pkg::CMD_CLEAR: begin
                    count_next = '0;
                end
                arat_pkg::CMD_APPEND: begin
                    if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                        tail_status_next = arat_pkg::ST_FULL;
                    end else if (last_tok.hit || !last_tok.size_ok) begin
                        tail_status_next = arat_pkg::ST_BAD;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                arat_pkg::CMD_LOOKUP: begin
                    if (last_tok.hit) begin
                        tail_attr_next = last_tok.hit_attr;
                    end else begin
                        tail_status_next = arat_pkg::ST_MISS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            tail_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_vld_reg   <= s_accept;
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            tail_vld_reg <= tail_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        if (s_accept) begin
            in_tok_reg <= in_tok_next;
        end
        tail_status_reg <= tail_status_next;
        tail_attr_reg   <= tail_attr_next;
        if (out_load) begin
            m_status_reg <= tail_status_reg;
            m_attr_reg   <= tail_attr_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_attribute = m_attr_reg;

    `ARAT_ALWAYS(a_count_range, count_reg <= CNT_W'(TABLE_DEPTH),
        "region count above table depth")
    `ARAT_ALWAYS(a_one_in_flight, $countones({chain_vld, tail_vld_reg}) <= 1,
        "more than one transaction in the chain")
    `ARAT_ASSERT(a_idle_empty, !busy_reg |-> (chain_vld == '0) && !tail_vld_reg,
        "chain holds a transaction while idle")
    `ARAT_ASSERT(a_miss_attr, m_valid && (m_status == arat_pkg::ST_MISS) |-> (m_attribute == '0),
        "miss carries an attribute")

endmodule

/* hdl/arat_cell.sv */
`timescale 1ns / 1ps
// One cell of the region chain: holds a single region and tests the passing query.
// Depends on arat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arat_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            entry_used,
    input  logic            wr_en,
    input  arat_pkg::entry_t wr_data,
    input  logic            tok_in_valid,
    input  arat_pkg::token_t tok_in,
    output logic            tok_out_valid,
    output arat_pkg::token_t tok_out
);

    arat_pkg::entry_t entry_reg;
    arat_pkg::token_t tok_reg;
    arat_pkg::token_t tok_next;
    logic             vld_reg;
    logic             match;

    // Half-open intervals [a, b) and [c, d) meet when a < d and c < b.
    // A lookup arrives as the one-byte interval [addr, addr + 1).
    assign match = entry_used
                && ({1'b0, tok_in.addr} < entry_reg.end_addr)
                && ({1'b0, entry_reg.start} < tok_in.end_addr);

    always_comb begin
        tok_next = tok_in;
        if (match && !tok_in.hit) begin
            tok_next.hit      = 1'b1;
            tok_next.hit_attr = entry_reg.attr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= tok_in_valid;
        end
        tok_reg <= tok_next;
        if (wr_en) begin
            entry_reg <= wr_data;
        end
    end

    assign tok_out_valid = vld_reg;
    assign tok_out       = tok_reg;

    `ARAT_ASSERT(a_hit_sticks, tok_in_valid && tok_in.hit |=> tok_out_valid && tok_out.hit, "hit flag lost in cell")

endmodule
